FILE: src/conv_window_neuron_mac_tanh_core_assert.svh
// Assertion macros used by the checker file of the neuron core.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef CONV_WINDOW_NEURON_MAC_TANH_CORE_ASSERT_SVH
`define CONV_WINDOW_NEURON_MAC_TANH_CORE_ASSERT_SVH

// Clocked check, switched off while reset is held
`define CWN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define CWN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/cwn_pkg.sv
// Shared constants, register codes and the tanh breakpoint table of the neuron core.
// No dependencies.
package cwn_pkg;

  // Default sizes of the weight store
  localparam int unsigned MAX_FIELDS_DEF = 4;
  localparam int unsigned MAX_WIN_DEF    = 8;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FIELDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MASK = 2'd3;

  // Item kinds carried on tuser of the input stream
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Q1.14 value of one
  localparam logic [14:0] TANH_ONE = 15'd16384;

  // tanh(0.5*i) in Q1.14, last point forced to one
  function automatic logic [14:0] tanh_pt(input logic [3:0] i);
    logic [14:0] r;
    case (i)
      4'd0:    r = 15'd0;
      4'd1:    r = 15'd7571;
      4'd2:    r = 15'd12478;
      4'd3:    r = 15'd14830;
      4'd4:    r = 15'd15795;
      4'd5:    r = 15'd16165;
      4'd6:    r = 15'd16303;
      4'd7:    r = 15'd16354;
      default: r = TANH_ONE;
    endcase
    return r;
  endfunction

endpackage

FILE: src/conv_window_neuron_mac_tanh_core.sv
// Convolutional neuron core: weight store, multiply-accumulate and tanh activation.
// Depends on cwn_pkg.
//
// Usage. Items arrive on the s_axis channel. tuser selects the kind: 0 loads
// tdata's value as a Q4.11 weight at (field, column, row), 1 brings a Q1.14
// window sample that is multiplied by its stored weight and accumulated. tlast
// on a sample closes the window and produces one result on m_axis: the
// saturated Q6.25 sum and its piecewise-linear tanh in Q1.14, with tuser set
// when field 0 is present and the kept values were refreshed.
// Registers are written on the cfg channel, which is always ready; write them
// only while no item is in flight.
// A load writes the weight memory on acceptance. A sample passes the weight
// memory read, registered multiply and accumulate steps. A last sample then
// passes the saturate, abs, table interpolation multiply and output stages
// before its result turns valid.
// A result waits in the output register; while it is not taken, a further last
// sample holds in its final stage and no new item is accepted.
// Reset clears the accumulator, the kept sum and activation, and restores the
// register defaults. Weight memory contents are undefined until loaded.
module conv_window_neuron_mac_tanh_core
  import cwn_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEF,
  parameter int unsigned MAX_WIN    = MAX_WIN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] field_index, [4:2] col_index, [7:5] row_index, [23:8] sample_value
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,   // last_sample
  input  logic                  s_axis_tuser,   // action
  // Result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] pre_activation, [47:32] activation
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser    // updated
);

  localparam int unsigned DEPTH  = MAX_FIELDS * MAX_WIN * MAX_WIN;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_SAT  = 3'd3;
  localparam logic [2:0] ST_ABS  = 3'd4;
  localparam logic [2:0] ST_TMUL = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  // Registers
  logic [2:0] num_fields_q;
  logic [3:0] win_width_q, win_height_q, field_mask_q;
  logic [2:0] state_q, state_d;

  // Input item fields
  logic [1:0]         in_field;
  logic [2:0]         in_col, in_row;
  logic signed [15:0] in_val;
  logic               in_acc, load_we, samp_acc, addr_ok, samp_ok;
  logic [ADDR_W-1:0]  addr;

  // Weight memory and datapath
  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rdata_q, val_q;
  logic               last_q, ok_q;
  logic signed [31:0] prod_q;
  logic signed [39:0] acc_q;
  logic signed [40:0] acc_sum;
  logic signed [31:0] pre_q;
  logic [31:0]        abs_q;
  logic               neg_q, big_q;
  logic [2:0]         seg;
  logic [14:0]        seg_d, base_q, y;
  logic [38:0]        tprod_q;

  // Kept values, which also form the output payload
  logic signed [31:0] kept_sum_q;
  logic signed [15:0] kept_out_q;
  logic               upd_q, m_valid_q;
  logic               out_free, out_fire, upd;

  assign in_field = s_axis_tdata[1:0];
  assign in_col   = s_axis_tdata[4:2];
  assign in_row   = s_axis_tdata[7:5];
  assign in_val   = s_axis_tdata[23:8];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign addr_ok       = (32'(in_field) < MAX_FIELDS) && (32'(in_col) < MAX_WIN) &&
                         (32'(in_row) < MAX_WIN);
  assign addr          = ADDR_W'((32'(in_field) * MAX_WIN + 32'(in_col)) * MAX_WIN +
                                 32'(in_row));
  assign load_we       = in_acc && (s_axis_tuser == ACT_LOAD) && addr_ok;
  assign samp_acc      = in_acc && (s_axis_tuser == ACT_SAMPLE);

  // Present field inside the configured window
  assign samp_ok = addr_ok && (in_field < 2'(MAX_FIELDS > 3 ? 3 : MAX_FIELDS) ||
                               MAX_FIELDS > 3) &&
                   ({1'b0, in_field} < num_fields_q) && field_mask_q[in_field] &&
                   ({1'b0, in_col} < win_width_q) && ({1'b0, in_row} < win_height_q);

  // Register writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_fields_q <= 3'd1;
      win_width_q  <= 4'd3;
      win_height_q <= 4'd3;
      field_mask_q <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NUM_FIELDS: num_fields_q <= cfg_data_i[2:0];
        CFG_WIN_WIDTH:  win_width_q  <= cfg_data_i;
        CFG_WIN_HEIGHT: win_height_q <= cfg_data_i;
        CFG_FIELD_MASK: field_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Weight memory: write on load, registered read on sample
  always_ff @(posedge clk_i) begin
    if (load_we) mem[addr] <= in_val;
    if (samp_acc) rdata_q <= mem[addr];
  end

  // Hold the sample while the weight is fetched
  always_ff @(posedge clk_i) begin
    if (samp_acc) begin
      val_q  <= in_val;
      last_q <= s_axis_tlast;
      ok_q   <= samp_ok;
    end
  end

  // Sequencer
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_fire = (state_q == ST_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (samp_acc) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = last_q ? ST_SAT : ST_IDLE;
      ST_SAT:  state_d = ST_ABS;
      ST_ABS:  state_d = ST_TMUL;
      ST_TMUL: state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Multiply sample by weight
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) prod_q <= val_q * rdata_q;
  end

  // Accumulate with 40-bit saturation, clear once the result is out
  assign acc_sum = {acc_q[39], acc_q} + 41'(prod_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (out_fire) begin
      acc_q <= '0;
    end else if (state_q == ST_ACC && ok_q) begin
      if (acc_sum[40] != acc_sum[39])
        acc_q <= acc_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      else
        acc_q <= acc_sum[39:0];
    end
  end

  // Saturate to 32 bits, take magnitude, interpolate the table
  assign seg   = abs_q[26:24];
  assign seg_d = tanh_pt({1'b0, seg} + 4'd1) - tanh_pt({1'b0, seg});

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SAT) begin
      if (acc_q[39:31] == {9{acc_q[39]}})
        pre_q <= acc_q[31:0];
      else
        pre_q <= acc_q[39] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end
    if (state_q == ST_ABS) begin
      neg_q <= pre_q[31];
      abs_q <= pre_q[31] ? 32'(~pre_q + 32'sd1) : pre_q;
    end
    if (state_q == ST_TMUL) begin
      big_q   <= |abs_q[31:27];
      base_q  <= tanh_pt({1'b0, seg});
      tprod_q <= 39'(seg_d) * 39'(abs_q[23:0]);
    end
  end

  assign y   = big_q ? TANH_ONE : base_q + tprod_q[38:24];
  assign upd = (num_fields_q != 3'd0) && field_mask_q[0];

  // Kept values and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_sum_q <= '0;
      kept_out_q <= '0;
      upd_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      if (out_fire) begin
        m_valid_q <= 1'b1;
        upd_q     <= upd;
        if (upd) begin
          kept_sum_q <= pre_q;
          kept_out_q <= neg_q ? 16'(16'd0 - {1'b0, y}) : {1'b0, y};
        end
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {kept_out_q, kept_sum_q};
  assign m_axis_tuser  = upd_q;

endmodule

FILE: src/cwn_checker.sv
// Port-level checks of the neuron core, attached by bind.
// Depends on cwn_pkg and conv_window_neuron_mac_tanh_core_assert.svh.
`include "conv_window_neuron_mac_tanh_core_assert.svh"

module cwn_checker
  import cwn_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  logic signed [31:0] pre;
  logic signed [15:0] act;
  logic               samp_acc;

  assign pre      = m_axis_tdata[31:0];
  assign act      = m_axis_tdata[47:32];
  assign samp_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_SAMPLE);

  // A stalled item holds
  `CWN_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // A sample occupies the multiply and accumulate stages
  `CWN_ASSERT(a_samp_busy, samp_acc |=> !s_axis_tready ##1 !s_axis_tready, "item accepted during multiply-accumulate")

  // Activation stays within plus and minus one
  `CWN_ASSERT(a_act_range, m_axis_tvalid |-> (act <= 16'sd16384) && (act >= -16'sd16384), "activation out of range")

  // tanh keeps the sign of its argument
  `CWN_ASSERT(a_act_sign, m_axis_tvalid |-> (pre[31] || !act[15]) && (pre != 32'sd0 || act == 16'sd0), "activation sign mismatch")

  // No result in the cycle after reset is seen
  `CWN_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind conv_window_neuron_mac_tanh_core cwn_checker u_cwn_checker (.*);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of conv_window_neuron_mac_tanh_core: random and directed items,
// with results checked against an in-bench predictor of the neuron.
// Depends on cwn_pkg and the core RTL.
module testbench
  import cwn_pkg::*;
();

  localparam int     DRAIN_CYCLES = 16;
  localparam longint ACC_MAX      = (longint'(1) <<< 39) - 1;
  localparam longint ACC_MIN      = -(longint'(1) <<< 39);
  localparam longint S32_MAX      = 64'sd2147483647;
  localparam longint S32_MIN      = -64'sd2147483648;

  typedef struct packed {
    logic               action;
    logic [1:0]         field;
    logic [2:0]         col;
    logic [2:0]         row;
    logic signed [15:0] value;
    logic               closes_window;
  } neuron_item_t;

  typedef struct packed {
    logic signed [31:0] pre_act;
    logic signed [15:0] act;
    logic               updated;
  } neuron_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  conv_window_neuron_mac_tanh_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: weights, accumulator, kept values and register copies
  logic signed [15:0] weight_mem [256];
  longint             acc_q      = 0;
  logic signed [31:0] kept_sum   = '0;
  logic signed [15:0] kept_act   = '0;
  logic [2:0]         nf_q       = 3'd1;
  logic [3:0]         win_w_q    = 4'd3;
  logic [3:0]         win_h_q    = 4'd3;
  logic [3:0]         mask_q     = 4'd1;
  int                 tanh_knots [9] = '{0, 7571, 12478, 14830, 15795, 16165, 16303, 16354,
                                         16384};

  neuron_item_t   pending_items [$];
  neuron_result_t expected_results [$];
  neuron_item_t   item_on_bus;
  int unsigned    src_idle_pct   = 0;
  int unsigned    sink_stall_pct = 0;
  int             mismatches     = 0;

  function automatic bit field_live(input logic [1:0] k);
    return (k < nf_q) && mask_q[k];
  endfunction

  // Piecewise-linear tanh over half-unit segments, odd in its argument
  function automatic logic signed [15:0] tanh_pwl(input logic signed [31:0] x);
    longint mag, seg, frac, y;
    mag  = (x < 0) ? -longint'(x) : longint'(x);
    seg  = mag >>> 24;
    frac = mag & 64'hFF_FFFF;
    if (seg >= 8) y = 16384;
    else y = tanh_knots[seg] + (((tanh_knots[seg+1] - tanh_knots[seg]) * frac) >>> 24);
    return (x < 0) ? 16'(-y) : 16'(y);
  endfunction

  // Advance the neuron by one accepted item; queue its result if it closes a window
  function automatic void apply_neuron_item(input neuron_item_t it);
    logic [7:0]     addr;
    longint         sum;
    neuron_result_t r;
    addr = {it.field, it.col, it.row};
    if (it.action == ACT_LOAD) begin
      weight_mem[addr] = it.value;
      return;
    end
    if (field_live(it.field) && it.col < win_w_q && it.row < win_h_q) begin
      sum = acc_q + longint'($signed(it.value)) * longint'(weight_mem[addr]);
      if (sum > ACC_MAX) sum = ACC_MAX;
      if (sum < ACC_MIN) sum = ACC_MIN;
      acc_q = sum;
    end
    if (!it.closes_window) return;
    r.updated = field_live(2'd0);
    if (r.updated) begin
      if (acc_q > S32_MAX) kept_sum = 32'h7FFF_FFFF;
      else if (acc_q < S32_MIN) kept_sum = 32'h8000_0000;
      else kept_sum = 32'(acc_q);
      kept_act = tanh_pwl(kept_sum);
    end
    acc_q     = 0;
    r.pre_act = kept_sum;
    r.act     = kept_act;
    expected_results.push_back(r);
  endfunction

  // Drive the input stream from the pending queue; predict on each accepted item
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) apply_neuron_item(item_on_bus);
    if (!s_axis_tvalid || s_axis_tready) begin
      if (rst_ni && pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        item_on_bus = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {item_on_bus.value, item_on_bus.row, item_on_bus.col,
                          item_on_bus.field};
        s_axis_tlast  <= item_on_bus.closes_window;
        s_axis_tuser  <= item_on_bus.action;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Take results with random stalls and compare with the oldest expectation
  always @(posedge clk_i) begin : result_monitor
    neuron_result_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result pre_activation=%0d activation=%0d updated=%0b",
                 $time, $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[47:32]),
                 m_axis_tuser);
        mismatches++;
      end else begin
        due = expected_results.pop_front();
        if (m_axis_tdata[31:0] !== due.pre_act) begin
          $display("%0t: pre_activation expected %0d got %0d", $time,
                   $signed(due.pre_act), $signed(m_axis_tdata[31:0]));
          mismatches++;
        end
        if (m_axis_tdata[47:32] !== due.act) begin
          $display("%0t: activation expected %0d got %0d", $time,
                   $signed(due.act), $signed(m_axis_tdata[47:32]));
          mismatches++;
        end
        if (m_axis_tuser !== due.updated) begin
          $display("%0t: updated expected %0b got %0b", $time, due.updated, m_axis_tuser);
          mismatches++;
        end
      end
    end
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic void push_item(input logic a, input logic [1:0] f, input logic [2:0] c,
                                    input logic [2:0] r, input logic [15:0] v,
                                    input logic cl);
    neuron_item_t it;
    it.action        = a;
    it.field         = f;
    it.col           = c;
    it.row           = r;
    it.value         = v;
    it.closes_window = cl;
    pending_items.push_back(it);
  endfunction

  // Extremes, all-ones, zero, or a random value of random magnitude
  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(7))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: begin
        v = 16'($urandom);
        v = $signed(v) >>> $urandom_range(15);
      end
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_live_field();
    logic [1:0] f;
    int         tries;
    f = 2'($urandom);
    for (tries = 0; tries < 16; tries++) begin
      if (field_live(f)) return f;
      f = 2'($urandom);
    end
    return f;
  endfunction

  // One window of samples on present fields; now and then it closes off-window
  task automatic queue_window(input int len);
    logic [1:0] f;
    logic [2:0] c, r;
    int         i, cw, rh;
    cw = (win_w_q > 8) ? 8 : win_w_q;
    rh = (win_h_q > 8) ? 8 : win_h_q;
    for (i = 0; i < len; i++) begin
      f = pick_live_field();
      c = (cw == 0) ? 3'($urandom) : 3'($urandom_range(cw - 1));
      r = (rh == 0) ? 3'($urandom) : 3'($urandom_range(rh - 1));
      if (i == len - 1 && $urandom_range(4) == 0) begin
        f = 2'($urandom);
        c = 3'($urandom);
        r = 3'($urandom);
      end
      push_item(ACT_SAMPLE, f, c, r, pick_value(), i == len - 1);
    end
  endtask

  // Mostly well-formed windows, the rest loose loads and samples
  task automatic queue_random(input int budget);
    int made, n, k;
    made = 0;
    while (made < budget) begin
      if ($urandom_range(9) < 7) begin
        n = $urandom_range(1, 16);
        queue_window(n);
      end else begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
          push_item($urandom_range(1) ? ACT_SAMPLE : ACT_LOAD, 2'($urandom), 3'($urandom),
                    3'($urandom), pick_value(), $urandom_range(2) == 0);
      end
      made += n;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_NUM_FIELDS: nf_q    = val[2:0];
      CFG_WIN_WIDTH:  win_w_q = val;
      CFG_WIN_HEIGHT: win_h_q = val;
      CFG_FIELD_MASK: mask_q  = val;
      default: ;
    endcase
  endtask

  // Hold until the stream is empty and every expected result has come
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    int p, k, nf, ww, wh, msk;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every weight first, so no sample reads an unwritten entry
    for (k = 0; k < 256; k++)
      push_item(ACT_LOAD, k[7:6], k[5:3], k[2:0], pick_value(), 1'b0);

    // Directed items under the reset register values
    push_item(ACT_LOAD,   2'd0, 3'd0, 3'd0, 16'h8000, 1'b1); // load ignores the last mark
    push_item(ACT_LOAD,   2'd0, 3'd2, 3'd2, 16'h7FFF, 1'b0);
    push_item(ACT_LOAD,   2'd0, 3'd1, 3'd1, 16'd2048, 1'b0); // one in Q4.11
    push_item(ACT_LOAD,   2'd3, 3'd7, 3'd7, 16'hFFFF, 1'b0);
    push_item(ACT_SAMPLE, 2'd0, 3'd0, 3'd0, 16'h8000, 1'b0);
    push_item(ACT_SAMPLE, 2'd0, 3'd0, 3'd0, 16'h8000, 1'b0);
    push_item(ACT_SAMPLE, 2'd0, 3'd2, 3'd2, 16'h7FFF, 1'b1); // clips to the top of 32 bits
    push_item(ACT_SAMPLE, 2'd0, 3'd0, 3'd0, 16'h7FFF, 1'b0);
    push_item(ACT_SAMPLE, 2'd0, 3'd0, 3'd0, 16'h7FFF, 1'b0);
    push_item(ACT_SAMPLE, 2'd0, 3'd0, 3'd0, 16'h7FFF, 1'b1); // clips to the bottom
    push_item(ACT_SAMPLE, 2'd0, 3'd1, 3'd1, 16'd16384, 1'b1); // segment boundary
    push_item(ACT_SAMPLE, 2'd0, 3'd1, 3'd1, 16'hE000, 1'b1);
    push_item(ACT_SAMPLE, 2'd0, 3'd1, 3'd1, 16'd1, 1'b1);
    push_item(ACT_SAMPLE, 2'd0, 3'd3, 3'd0, 16'h7FFF, 1'b0); // column outside the window
    push_item(ACT_SAMPLE, 2'd0, 3'd0, 3'd3, 16'h7FFF, 1'b0); // row outside the window
    push_item(ACT_SAMPLE, 2'd3, 3'd7, 3'd7, 16'h8000, 1'b0); // absent field
    push_item(ACT_SAMPLE, 2'd1, 3'd0, 3'd0, 16'd100, 1'b1);  // absent field still closes
    push_item(ACT_SAMPLE, 2'd0, 3'd1, 3'd1, 16'd0, 1'b1);
    push_item(ACT_SAMPLE, 2'd0, 3'd1, 3'd1, 16'h7FFF, 1'b1);
    queue_random(140);

    // Register settings in turn, each with one of four idling patterns
    for (p = 1; p <= 8; p++) begin
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      case (p)
        1: begin nf = 4;  ww = 8;  wh = 8;  msk = 15; end
        2: begin nf = 1;  ww = 1;  wh = 1;  msk = 1;  end
        3: begin nf = 0;  ww = 8;  wh = 8;  msk = 15; end
        4: begin nf = 15; ww = 15; wh = 15; msk = 15; end
        5: begin nf = 4;  ww = 8;  wh = 8;  msk = 14; end
        6: begin nf = 3;  ww = 5;  wh = 2;  msk = 11; end
        7: begin nf = 2;  ww = 4;  wh = 6;  msk = 3;  end
        default: begin
          nf  = $urandom_range(7);
          ww  = $urandom_range(1, 8);
          wh  = $urandom_range(1, 8);
          msk = $urandom_range(15);
        end
      endcase
      write_reg(CFG_NUM_FIELDS, 4'(nf));
      write_reg(CFG_WIN_WIDTH, 4'(ww));
      write_reg(CFG_WIN_HEIGHT, 4'(wh));
      write_reg(CFG_FIELD_MASK, 4'(msk));
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 79; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 79; end
        default: begin src_idle_pct = 35; sink_stall_pct = 35; end
      endcase
      // Long window that drives the accumulator into its 40-bit clip and back out
      if (p == 1) begin
        push_item(ACT_LOAD, 2'd0, 3'd0, 3'd0, 16'h8000, 1'b0);
        repeat (520) push_item(ACT_SAMPLE, 2'd0, 3'd0, 3'd0, 16'h8000, 1'b0);
        for (k = 0; k < 16; k++)
          push_item(ACT_SAMPLE, 2'd0, 3'd0, 3'd0, 16'h7FFF, k == 15);
      end
      queue_random(100);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Give up long after the slowest correct run would have ended
  initial begin : watchdog
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
